/* hdl/rdrg_pkg.sv */
`default_nettype none
package rdrg_pkg;

  localparam int unsigned CW = 46;
  localparam int unsigned ZW = 33;
  localparam int unsigned CORDIC_STEPS = 30;

  localparam logic signed [ZW-1:0] HALF_PI_Z = 33'sd843314857;
  localparam logic signed [CW-1:0] NORM_HI = 46'sd1099511627775;
  localparam logic signed [CW-1:0] NORM_LO = -46'sd1099511627775;

  localparam logic [1:0] CFG_ANGLE_TOL = 2'd0;
  localparam logic [1:0] CFG_POS_TOL   = 2'd1;
  localparam logic [1:0] CFG_SPEED     = 2'd2;
  localparam logic [1:0] CFG_GAIN      = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TURN  = 2'd1,
    PH_DRIVE = 2'd2,
    PH_FINAL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_NORM,
    A_ITER,
    A_DONE
  } atan_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ATAN,
    S_EVAL,
    S_SQX,
    S_SQY,
    S_SQT,
    S_CMP,
    S_MUL,
    S_DIV,
    S_SAT,
    S_DONE
  } state_e;

  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:    a = 33'sd421657428;
      5'd1:    a = 33'sd248918915;
      5'd2:    a = 33'sd131521918;
      5'd3:    a = 33'sd66762581;
      5'd4:    a = 33'sd33510843;
      5'd5:    a = 33'sd16771758;
      5'd6:    a = 33'sd8387925;
      5'd7:    a = 33'sd4194219;
      5'd8:    a = 33'sd2097141;
      5'd9:    a = 33'sd1048575;
      5'd10:   a = 33'sd524288;
      5'd11:   a = 33'sd262144;
      default: a = 33'sd1 <<< (5'd29 - i);
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* hdl/rdrg_atan2.sv */
`default_nettype none
module rdrg_atan2 (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [32:0] dx_i,
  input  wire logic signed [32:0] dy_i,
  output logic                    done_o,
  output logic signed [15:0]      angle_o
);
  import rdrg_pkg::*;

  atan_state_e st_q, st_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0] z_q, z_d, zr;
  logic [4:0] i_q, i_d;
  logic small_x, small_y;

  assign small_x = (x_q >= NORM_LO) && (x_q <= NORM_HI);
  assign small_y = (y_q >= NORM_LO) && (y_q <= NORM_HI);
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign zr = z_q + 33'sd32768;
  assign angle_o = zr[31:16];
  assign done_o = (st_q == A_DONE);

  always_comb begin
    st_d = st_q;
    case (st_q)
      A_IDLE: begin
        if (start_i) begin
          st_d = (dx_i == 33'sd0 && dy_i == 33'sd0) ? A_DONE : A_NORM;
        end
      end
      A_NORM: begin
        if (!(small_x && small_y)) begin
          st_d = A_ITER;
        end
      end
      A_ITER: begin
        if (i_q == 5'(CORDIC_STEPS - 1)) begin
          st_d = A_DONE;
        end
      end
      A_DONE:  st_d = A_IDLE;
      default: st_d = A_IDLE;
    endcase
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    case (st_q)
      A_IDLE: begin
        x_d = CW'(dx_i);
        y_d = CW'(dy_i);
        z_d = '0;
        i_d = '0;
      end
      A_NORM: begin
        if (small_x && small_y) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else if (x_q < 0) begin
          if (y_q >= 0) begin
            x_d = y_q;
            y_d = -x_q;
            z_d = HALF_PI_Z;
          end else begin
            x_d = -y_q;
            y_d = x_q;
            z_d = -HALF_PI_Z;
          end
        end
      end
      A_ITER: begin
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_step(i_q);
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_step(i_q);
        end
        i_d = i_q + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= A_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    i_q <= i_d;
  end

endmodule
`default_nettype wire

/* hdl/rotate_drive_rotate_goal_controller_top.sv */
// Three-phase go-to-goal steering controller.
// Input channel (in_valid_i / in_stall_o): cmd_i = 0 brings a goal pose,
// cmd_i = 1 an odometry pose. One word is taken when valid is high and
// stall is low; the block stalls while it works on a word.
// Output channel (out_valid_o / out_stall_i): one command word per input
// word, held in an output register until the receiver takes it. The next
// input word is taken while that result waits; its own result then waits
// in the sequencer until the output register frees.
// Config channel (cfg_valid_i / cfg_ready_o): ready is always high; write
// only while the block is idle.
// The datapath uses a shared 24x24 multiplier, a bit-serial restoring
// divider and a word-serial CORDIC. A goal word first passes the
// normalizer and CORDIC, which are skipped when the goal sits on the
// robot position.
// Reset clears the phase to idle, poses to zero and the tolerances, speed
// and gain to their defaults; no result is pending after reset.
`default_nettype none
module rotate_drive_rotate_goal_controller_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               cmd_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [15:0] yaw_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [17:0]             linear_cmd_o,
  output logic signed [15:0]      angular_cmd_o,
  output logic [1:0]              phase_now_o,
  output logic                    goal_done_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i
);
  import rdrg_pkg::*;

  state_e st_q, st_d;
  phase_e phase_q, phase_d;

  logic [14:0] ang_tol_q, gain_q;
  logic [23:0] pos_tol_q;
  logic [17:0] speed_q;

  logic signed [31:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic signed [31:0] rob_x_q, rob_x_d, rob_y_q, rob_y_d;
  logic signed [15:0] goal_yaw_q, goal_yaw_d, rob_yaw_q, rob_yaw_d;
  logic signed [15:0] head_q, head_d;
  logic signed [16:0] init_q, init_d, err_q, err_d, err1, err3;

  logic [23:0] ax_q, ax_d, ay_q, ay_d;
  logic [48:0] acc_q, acc_d;
  logic [47:0] tsq_q, tsq_d, prod;
  logic [23:0] mul_a, mul_b;
  logic [31:0] dvd_q, dvd_d;
  logic [16:0] den_q, den_d, rem_q, rem_d, mag_err, mag_init;
  logic [17:0] trial;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] dx_far, dy_far, adx, ady;

  logic [17:0] res_lin_q, res_lin_d;
  logic signed [15:0] res_ang_q, res_ang_d;
  logic res_done_q, res_done_d;

  logic out_valid_q, out_valid_d, out_load;
  logic [17:0] out_lin_q;
  logic signed [15:0] out_ang_q;
  logic [1:0] out_phase_q;
  logic out_done_q;

  logic in_acc, atan_start, atan_done;
  logic signed [32:0] atan_dx, atan_dy;
  logic signed [15:0] atan_angle;

  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  assign in_stall_o  = (st_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign atan_start  = in_acc && !cmd_i;
  assign atan_dx     = 33'(pos_x_i) - 33'(rob_x_q);
  assign atan_dy     = 33'(pos_y_i) - 33'(rob_y_q);

  rdrg_atan2 u_atan2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (atan_start),
    .dx_i    (atan_dx),
    .dy_i    (atan_dy),
    .done_o  (atan_done),
    .angle_o (atan_angle)
  );

  assign err1     = 17'(head_q) - 17'(rob_yaw_q);
  assign err3     = 17'(goal_yaw_q) - 17'(rob_yaw_q);
  assign mag_err  = mag17(err_q);
  assign mag_init = mag17(init_q);
  assign dx_far   = 33'(goal_x_q) - 33'(rob_x_q);
  assign dy_far   = 33'(goal_y_q) - 33'(rob_y_q);
  assign adx      = dx_far[32] ? -dx_far : dx_far;
  assign ady      = dy_far[32] ? -dy_far : dy_far;
  assign trial    = {rem_q, dvd_q[31]};

  always_comb begin
    case (st_q)
      S_SQX:   begin mul_a = ax_q;  mul_b = ax_q; end
      S_SQY:   begin mul_a = ay_q;  mul_b = ay_q; end
      S_SQT:   begin mul_a = pos_tol_q; mul_b = pos_tol_q; end
      default: begin mul_a = 24'(gain_q); mul_b = 24'(mag_err); end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign out_load = (st_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          st_d = cmd_i ? S_EVAL : S_ATAN;
        end
      end
      S_ATAN: begin
        if (atan_done) begin
          st_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (phase_q)
          PH_TURN:  st_d = (mag17(err1) > 17'(ang_tol_q)) ? S_MUL : S_DONE;
          PH_FINAL: st_d = (mag17(err3) > 17'(ang_tol_q)) ? S_MUL : S_DONE;
          PH_DRIVE: st_d = (adx[32:24] != '0 || ady[32:24] != '0) ? S_DONE : S_SQX;
          default:  st_d = S_DONE;
        endcase
      end
      S_SQX: st_d = S_SQY;
      S_SQY: st_d = S_SQT;
      S_SQT: st_d = S_CMP;
      S_CMP: st_d = S_DONE;
      S_MUL: st_d = S_DIV;
      S_DIV: begin
        if (cnt_q == 5'd31) begin
          st_d = S_SAT;
        end
      end
      S_SAT: st_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    goal_x_d   = goal_x_q;
    goal_y_d   = goal_y_q;
    goal_yaw_d = goal_yaw_q;
    rob_x_d    = rob_x_q;
    rob_y_d    = rob_y_q;
    rob_yaw_d  = rob_yaw_q;
    head_d     = head_q;
    init_d     = init_q;
    err_d      = err_q;
    ax_d       = ax_q;
    ay_d       = ay_q;
    acc_d      = acc_q;
    tsq_d      = tsq_q;
    dvd_d      = dvd_q;
    den_d      = den_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    res_lin_d  = res_lin_q;
    res_ang_d  = res_ang_q;
    res_done_d = res_done_q;
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_i) begin
            rob_x_d   = pos_x_i;
            rob_y_d   = pos_y_i;
            rob_yaw_d = yaw_i;
          end else begin
            goal_x_d   = pos_x_i;
            goal_y_d   = pos_y_i;
            goal_yaw_d = yaw_i;
          end
        end
      end
      S_ATAN: begin
        if (atan_done) begin
          head_d  = atan_angle;
          init_d  = 17'(atan_angle) - 17'(rob_yaw_q);
          phase_d = PH_TURN;
        end
      end
      S_EVAL: begin
        res_lin_d  = '0;
        res_ang_d  = '0;
        res_done_d = 1'b0;
        ax_d       = adx[23:0];
        ay_d       = ady[23:0];
        case (phase_q)
          PH_TURN: begin
            err_d = err1;
            if (!(mag17(err1) > 17'(ang_tol_q))) begin
              phase_d = PH_DRIVE;
            end
          end
          PH_FINAL: begin
            err_d = err3;
            if (!(mag17(err3) > 17'(ang_tol_q))) begin
              phase_d    = PH_IDLE;
              res_done_d = 1'b1;
            end
          end
          PH_DRIVE: begin
            if (adx[32:24] != '0 || ady[32:24] != '0) begin
              res_lin_d = speed_q;
            end
          end
          default: ;
        endcase
      end
      S_SQX: acc_d = {1'b0, prod};
      S_SQY: acc_d = acc_q + {1'b0, prod};
      S_SQT: tsq_d = prod;
      S_CMP: begin
        if (acc_q > {1'b0, tsq_q}) begin
          res_lin_d = speed_q;
        end else begin
          init_d  = err3;
          phase_d = PH_FINAL;
        end
      end
      S_MUL: begin
        dvd_d = prod[31:0];
        den_d = (mag_init == '0) ? 17'd1 : mag_init;
        rem_d = '0;
        cnt_d = '0;
      end
      S_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = 17'(trial - {1'b0, den_q});
          dvd_d = {dvd_q[30:0], 1'b1};
        end else begin
          rem_d = trial[16:0];
          dvd_d = {dvd_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
      end
      S_SAT: begin
        if (err_q[16]) begin
          res_ang_d = (dvd_q > 32'd32768) ? 16'sh8000 : 16'(32'd0 - dvd_q);
        end else begin
          res_ang_d = (dvd_q > 32'd32767) ? 16'sd32767 : 16'(dvd_q);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      ang_tol_q   <= 15'd819;
      pos_tol_q   <= 24'd6554;
      speed_q     <= 18'd13107;
      gain_q      <= 15'd16384;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      goal_yaw_q  <= '0;
      rob_x_q     <= '0;
      rob_y_q     <= '0;
      rob_yaw_q   <= '0;
      head_q      <= '0;
      init_q      <= '0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      goal_yaw_q  <= goal_yaw_d;
      rob_x_q     <= rob_x_d;
      rob_y_q     <= rob_y_d;
      rob_yaw_q   <= rob_yaw_d;
      head_q      <= head_d;
      init_q      <= init_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ANGLE_TOL: ang_tol_q <= cfg_data_i[14:0];
          CFG_POS_TOL:   pos_tol_q <= cfg_data_i;
          CFG_SPEED:     speed_q   <= cfg_data_i[17:0];
          CFG_GAIN:      gain_q    <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    acc_q      <= acc_d;
    tsq_q      <= tsq_d;
    dvd_q      <= dvd_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    res_lin_q  <= res_lin_d;
    res_ang_q  <= res_ang_d;
    res_done_q <= res_done_d;
    if (out_load) begin
      out_lin_q   <= res_lin_q;
      out_ang_q   <= res_ang_q;
      out_phase_q <= phase_q;
      out_done_q  <= res_done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign linear_cmd_o  = out_lin_q;
  assign angular_cmd_o = out_ang_q;
  assign phase_now_o   = out_phase_q;
  assign goal_done_o   = out_done_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken but block not busy");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && goal_done_o) |-> (phase_now_o == PH_IDLE))
    else $error("goal done outside idle phase");

  a_drive_no_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && linear_cmd_o != '0) |->
      (angular_cmd_o == '0 && phase_now_o == PH_DRIVE))
    else $error("forward command outside drive phase");

endmodule
`default_nettype wire
